// ===== sv/hsl2rgb_pkg.sv =====
// shared constants and phase helpers for the hsl to rgb colour converter
`timescale 1ns / 1ps

package hsl2rgb_pkg;

  // phase is kept in units of 1/196608 turn so that thirds are exact
  localparam int unsigned PHASE_W = 18;
  localparam int unsigned WEIGHT_W = 16;

  localparam logic [PHASE_W:0] PHASE_TURN       = 19'd196608;
  localparam logic [PHASE_W:0] PHASE_THIRD      = 19'd65536;
  localparam logic [PHASE_W:0] PHASE_TWO_THIRDS = 19'd131072;
  localparam logic [PHASE_W-1:0] PHASE_SIXTH    = 18'd32768;
  localparam logic [PHASE_W-1:0] PHASE_HALF     = 18'd98304;
  localparam logic [PHASE_W-1:0] PHASE_RAMP_END = 18'd131072;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 16'd32768;

  // channel lanes
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned NUM_CH   = 3;

  localparam int unsigned HUE_W   = 16;
  localparam int unsigned COMP_W  = 19;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 24;

  // offset a phase by a constant below one turn, wrapping at one turn
  function automatic logic [PHASE_W-1:0] phase_offset(input logic [PHASE_W-1:0] t,
                                                      input logic [PHASE_W:0] offs);
    logic [PHASE_W:0] sum;
    sum = {1'b0, t} + offs;
    if (sum >= PHASE_TURN) begin
      sum = sum - PHASE_TURN;
    end
    return sum[PHASE_W-1:0];
  endfunction

  // piecewise hue ramp: weight of q against p, 0 .. 32768
  function automatic logic [WEIGHT_W-1:0] ramp_weight(input logic [PHASE_W-1:0] t);
    logic [PHASE_W-1:0] fall;
    logic [WEIGHT_W-1:0] d;
    fall = PHASE_RAMP_END - t;
    priority if (t < PHASE_SIXTH) begin
      d = t[WEIGHT_W-1:0];
    end else if (t < PHASE_HALF) begin
      d = WEIGHT_FULL;
    end else if (t < PHASE_RAMP_END) begin
      d = fall[WEIGHT_W-1:0];
    end else begin
      d = '0;
    end
    return d;
  endfunction

endpackage

// ===== sv/hsl_to_rgb_converter.sv =====
// hsl to rgb colour converter, five stage pipeline
`timescale 1ns / 1ps

// hsl to rgb colour converter
//
// input channel (in_*): one hsl colour per request. hue is an unsigned
// fraction of a turn that wraps; saturation and lightness are signed fixed
// point with FRAC_BITS fraction bits and are clamped to 0..1
// output channel (out_*): one rgb request per input request, 8 bits a channel,
// round to nearest of value times 255, halves rounded up
//
// throughput: one colour per clock, sustained, as long as the receiver takes
// results; each request passes through the five stages clamp, s*m product,
// ramp product, blend sum, scale by 255 and round; the output register is the
// last stage
//
// reset clears every stage valid bit; payload registers are not reset
// when the receiver stalls, each stage holds while the one after it is full
// and not moving, and a stage with a bubble still fills, so nothing is lost or
// repeated; in_tready falls only once all five stages hold requests
module hsl_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // hue [15:0], saturation [34:16], lightness [53:35], zero pad [55:54]
  input  logic [hsl2rgb_pkg::IN_DATA_W-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [hsl2rgb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import hsl2rgb_pkg::*;

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned UW   = F + 1;            // clamped unit value, holds 1.0
  localparam int unsigned CMPW = (F + 1 > 18) ? F + 1 : 18;
  localparam int unsigned SMW  = 2 * F;            // s*m, at most 2^(2F-1)
  localparam int unsigned PW   = 2 * F + 1;        // p in 1/S^2 units
  localparam int unsigned PRW  = SMW + WEIGHT_W;   // s*m*d
  localparam int unsigned M    = 2 * F + 15;       // blend scale exponent
  localparam int unsigned WW   = M + 1;            // blend value, up to 2^M
  localparam int unsigned SCW  = WW + 8;           // 255*w plus rounding

  localparam logic [CMPW-1:0] ONE_C   = CMPW'(1) << F;
  localparam logic [UW-1:0]   ONE_U   = UW'(1) << F;
  localparam logic [UW-1:0]   HALF_U  = UW'(1) << (F - 1);
  localparam logic [WW-1:0]   W_MAX   = WW'(1) << M;
  localparam logic [SCW-1:0]  ROUND_C = SCW'(1) << (M - 1);

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5_r || out_tready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  // clamp to 0 .. 1.0
  function automatic logic [UW-1:0] clamp_unit(input logic [COMP_W-1:0] raw);
    logic [CMPW-1:0] v;
    logic [UW-1:0] res;
    v = CMPW'(raw[COMP_W-2:0]);
    priority if (raw[COMP_W-1]) begin
      res = '0;
    end else if (v > ONE_C) begin
      res = ONE_U;
    end else begin
      res = v[UW-1:0];
    end
    return res;
  endfunction

  // stage 1: clamp and triple the hue
  logic [UW-1:0]      s1_sat_r, s1_sat_nxt;
  logic [UW-1:0]      s1_lit_r, s1_lit_nxt;
  logic [PHASE_W-1:0] s1_h3_r, s1_h3_nxt;

  always_comb begin
    s1_sat_nxt = clamp_unit(in_tdata[HUE_W +: COMP_W]);
    s1_lit_nxt = clamp_unit(in_tdata[HUE_W + COMP_W +: COMP_W]);
    s1_h3_nxt  = {2'b00, in_tdata[HUE_W-1:0]} + {1'b0, in_tdata[HUE_W-1:0], 1'b0};
  end

  // stage 2: m = min(l, 1-l), product s*m, ramp weights for each channel
  logic [F-1:0]       s2_m;
  logic [UW+F-1:0]    s2_sm_full;
  logic [SMW-1:0]     s2_sm_r, s2_sm_nxt;
  logic [UW-1:0]      s2_lit_r;
  logic [WEIGHT_W-1:0] s2_d_r [NUM_CH];
  logic [WEIGHT_W-1:0] s2_d_nxt [NUM_CH];

  always_comb begin
    if (s1_lit_r < HALF_U) begin
      s2_m = s1_lit_r[F-1:0];
    end else begin
      s2_m = F'(ONE_U - s1_lit_r);
    end
    s2_sm_full = {{F{1'b0}}, s1_sat_r} * {{UW{1'b0}}, s2_m};
    s2_sm_nxt  = s2_sm_full[SMW-1:0];
    s2_d_nxt[CH_RED]   = ramp_weight(phase_offset(s1_h3_r, PHASE_THIRD));
    s2_d_nxt[CH_GREEN] = ramp_weight(s1_h3_r);
    s2_d_nxt[CH_BLUE]  = ramp_weight(phase_offset(s1_h3_r, PHASE_TWO_THIRDS));
  end

  // stage 3: p = l - s*m, swing per channel s*m*d
  logic [PW-1:0]  s3_p_r, s3_p_nxt;
  logic [PRW-1:0] s3_prod_r [NUM_CH];
  logic [PRW-1:0] s3_prod_nxt [NUM_CH];

  always_comb begin
    s3_p_nxt = {s2_lit_r, {F{1'b0}}} - PW'(s2_sm_r);
    for (int i = 0; i < NUM_CH; i++) begin
      s3_prod_nxt[i] = {{WEIGHT_W{1'b0}}, s2_sm_r} * {{SMW{1'b0}}, s2_d_r[i]};
    end
  end

  // stage 4: blend w = p*32768 + (q-p)*d, with q-p = 2*s*m
  logic [WW-1:0] s4_w_r [NUM_CH];
  logic [WW-1:0] s4_w_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s4_w_nxt[i] = {s3_p_r, 15'b0} + WW'({s3_prod_r[i], 1'b0});
    end
  end

  // stage 5: times 255, round half up, keep the top byte
  logic [SCW-1:0]    s5_scaled [NUM_CH];
  logic [CHAN_W-1:0] s5_rgb_r [NUM_CH];
  logic [CHAN_W-1:0] s5_rgb_nxt [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      s5_scaled[i]  = {s4_w_r[i], 8'b0} - SCW'(s4_w_r[i]) + ROUND_C;
      s5_rgb_nxt[i] = s5_scaled[i][M +: CHAN_W];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_sat_r <= s1_sat_nxt;
      s1_lit_r <= s1_lit_nxt;
      s1_h3_r  <= s1_h3_nxt;
    end
    if (rdy2) begin
      s2_sm_r  <= s2_sm_nxt;
      s2_lit_r <= s1_lit_r;
      for (int i = 0; i < NUM_CH; i++) begin
        s2_d_r[i] <= s2_d_nxt[i];
      end
    end
    if (rdy3) begin
      s3_p_r <= s3_p_nxt;
      for (int i = 0; i < NUM_CH; i++) begin
        s3_prod_r[i] <= s3_prod_nxt[i];
      end
    end
    if (rdy4) begin
      for (int i = 0; i < NUM_CH; i++) begin
        s4_w_r[i] <= s4_w_nxt[i];
      end
    end
    if (rdy5) begin
      for (int i = 0; i < NUM_CH; i++) begin
        s5_rgb_r[i] <= s5_rgb_nxt[i];
      end
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {s5_rgb_r[CH_BLUE], s5_rgb_r[CH_GREEN], s5_rgb_r[CH_RED]};

  // a request leaving the blend stage lands in the output register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && rdy5 |=> v5_r)
    else $error("blend stage request lost on its way to the output");

  // a blocked first stage keeps its request intact
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(s1_sat_r) && $stable(s1_lit_r) && $stable(s1_h3_r))
    else $error("first stage changed while blocked");

  // blend never goes above 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (s4_w_r[CH_RED] <= W_MAX) && (s4_w_r[CH_GREEN] <= W_MAX)
             && (s4_w_r[CH_BLUE] <= W_MAX))
    else $error("blend value out of range");

  // equal blends give a gray output
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && rdy5 && (s4_w_r[CH_RED] == s4_w_r[CH_GREEN])
      && (s4_w_r[CH_GREEN] == s4_w_r[CH_BLUE])
    |=> (s5_rgb_r[CH_RED] == s5_rgb_r[CH_GREEN]) && (s5_rgb_r[CH_GREEN] == s5_rgb_r[CH_BLUE]))
    else $error("equal blends did not give equal channels");

endmodule
